/* rtl/core/bftl_pkg.sv */
// Shared types and constants for the bilinear force table lookup.
// Holds the beat structs, the operation codes and the fixed-point grid geometry.
// No dependencies.
`default_nettype none

package bftl_pkg;

  // Position scale and grid spacing; the spacing is a power of two so the
  // index and fraction are a plain bit split of the offset.
  localparam int POS_PER_MICRON     = 256;
  localparam int SAMPLES_PER_MICRON = 4;
  localparam int STEP               = POS_PER_MICRON / SAMPLES_PER_MICRON;
  localparam int FRAC_W             = $clog2(STEP);
  // Bilinear weights reach STEP*STEP and need one bit more than two fractions.
  localparam int WGT_W              = 2 * FRAC_W + 1;

  // Lookup window in position units, bounds included.
  localparam int R_LO_POS = 0 * POS_PER_MICRON;
  localparam int R_HI_POS = 20 * POS_PER_MICRON;
  localparam int Z_LO_POS = -20 * POS_PER_MICRON;
  localparam int Z_HI_POS = 8 * POS_PER_MICRON;

  // Offsets inside the window; the axial span is the wider one.
  localparam int OFF_W = $clog2(Z_HI_POS - Z_LO_POS + 1);
  localparam int IDX_W = OFF_W - FRAC_W;

  // Default grid size.
  localparam int RADIAL_POINTS_DEF = 81;
  localparam int AXIAL_POINTS_DEF  = 113;

  localparam int SAMPLE_W  = 32;
  localparam int POS_W     = 16;
  localparam int INDEX_W   = 7;
  // Result queue depth; two covers the lookups that can be in flight.
  localparam int OUT_DEPTH = 2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } bftl_op_t;

  typedef struct packed {
    bftl_op_t                    operation;
    logic [INDEX_W-1:0]          row_index;
    logic [INDEX_W-1:0]          column_index;
    logic signed [SAMPLE_W-1:0]  radial_sample;
    logic signed [SAMPLE_W-1:0]  axial_sample;
    logic signed [POS_W-1:0]     radial_position;
    logic signed [POS_W-1:0]     axial_position;
  } bftl_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  radial_force;
    logic signed [SAMPLE_W-1:0]  axial_force;
    logic                        in_range;
  } bftl_out_t;

  // Tag that travels with each table read into the accumulator.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic              oob;
    logic [WGT_W-1:0]  weight;
  } bftl_tag_t;

endpackage

`default_nettype wire

/* rtl/core/bftl_accum.sv */
// Weighting, accumulation and result queue of the bilinear force table lookup.
// Depends on bftl_pkg for the tag and result beat types.
`default_nettype none

module bftl_accum (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [2*bftl_pkg::SAMPLE_W-1:0] rd_data,
  input  bftl_pkg::bftl_tag_t        tag_in,
  input  logic                       lookup_start,
  output logic                       credit_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bftl_pkg::bftl_out_t        out_data
);

  localparam int SAMPLE_W = bftl_pkg::SAMPLE_W;
  localparam int PROD_W   = SAMPLE_W + bftl_pkg::WGT_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int SHIFT    = 2 * bftl_pkg::FRAC_W;
  localparam int DEPTH    = bftl_pkg::OUT_DEPTH;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (SHIFT - 1);

  logic signed [PROD_W-1:0] prod_rad, prod_ax;
  logic signed [PROD_W-1:0] prod_rad_r, prod_ax_r;
  bftl_pkg::bftl_tag_t      tag2_r;
  logic signed [ACC_W-1:0]  acc_rad_r, acc_ax_r, acc_rad_nxt, acc_ax_nxt;
  bftl_pkg::bftl_out_t      push_data;
  logic                     push, pop;

  bftl_pkg::bftl_out_t      queue_r [DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt, pending_r, pending_nxt;

  // Weight each component of the entry just read; out-of-window slots give zero.
  assign prod_rad = $signed(rd_data[SAMPLE_W-1:0]) * $signed({1'b0, tag_in.weight});
  assign prod_ax  = $signed(rd_data[2*SAMPLE_W-1:SAMPLE_W]) * $signed({1'b0, tag_in.weight});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else begin
      tag2_r <= tag_in;
    end
    prod_rad_r <= tag_in.oob ? '0 : prod_rad;
    prod_ax_r  <= tag_in.oob ? '0 : prod_ax;
  end

  // Accumulate the four products; the first one starts from the rounding bias.
  assign acc_rad_nxt = (tag2_r.first ? $signed(ROUND_BIAS) : acc_rad_r) + ACC_W'(prod_rad_r);
  assign acc_ax_nxt  = (tag2_r.first ? $signed(ROUND_BIAS) : acc_ax_r) + ACC_W'(prod_ax_r);

  always_ff @(posedge clk) begin
    if (tag2_r.valid) begin
      acc_rad_r <= acc_rad_nxt;
      acc_ax_r  <= acc_ax_nxt;
    end
  end

  // The last product closes the sum; the arithmetic shift rounds half up.
  always_comb begin
    push_data.radial_force = tag2_r.oob ? '0 : acc_rad_nxt[SHIFT +: SAMPLE_W];
    push_data.axial_force  = tag2_r.oob ? '0 : acc_ax_nxt[SHIFT +: SAMPLE_W];
    push_data.in_range     = !tag2_r.oob;
  end

  assign push = tag2_r.valid && tag2_r.last;
  assign pop  = out_valid && !out_stall;

  // Result queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    fill_nxt    = CNT_W'(fill_r + CNT_W'(push) - CNT_W'(pop));
    pending_nxt = CNT_W'(pending_r + CNT_W'(lookup_start) - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      pending_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      fill_r    <= fill_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= push_data;
    end
  end

  // A lookup may start only when its result is sure to find a queue slot.
  assign credit_ok = (pending_r < CNT_W'(DEPTH));
  assign out_valid = (fill_r != '0);
  assign out_data  = queue_r[rd_ptr_r];

endmodule

`default_nettype wire

/* rtl/core/bilinear_force_table_lookup.sv */
// Top level of the bilinear force table lookup: beat decode, table memory and read sequencer.
// Depends on bftl_pkg and instantiates bftl_accum.
//
// Usage: every input beat is either a load or a lookup. A load writes one
// grid entry (row, column, radial and axial sample) and returns no beat;
// a row or column beyond the grid is dropped. A lookup takes a radial and
// an axial position in 1/256 micron and returns one result beat with the
// bilinearly interpolated radial and axial force and an in-range flag.
// Positions outside radial 0..20 um or axial -20..8 um give zero forces
// and a cleared flag. Results leave in the order the lookups came in.
// The single-port table memory is the limit on the rate. A lookup inside
// the window makes four reads, one per neighbour; a load makes at most one
// write and an out-of-window lookup none. A new beat is taken in the cycle
// the previous one makes its last memory access, unless two lookups are
// outstanding.
// Reset clears the sequencer and the result queue, not the table: an
// entry must be loaded before a lookup touches it. When the receiver
// stalls, up to two results wait in the queue; while two lookups are
// outstanding every further beat, load or lookup, is held off.
`default_nettype none

module bilinear_force_table_lookup #(
  parameter int RADIAL_POINTS = bftl_pkg::RADIAL_POINTS_DEF,
  parameter int AXIAL_POINTS  = bftl_pkg::AXIAL_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bftl_pkg::bftl_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bftl_pkg::bftl_out_t  out_data
);

  localparam int GRID_DEPTH = RADIAL_POINTS * AXIAL_POINTS;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int COL_W      = $clog2(RADIAL_POINTS);
  localparam int ROW_W      = $clog2(AXIAL_POINTS);
  localparam int FRAC_W     = bftl_pkg::FRAC_W;
  localparam int FW1        = FRAC_W + 1;
  localparam int WGT_W      = bftl_pkg::WGT_W;
  localparam int OFF_W      = bftl_pkg::OFF_W;
  localparam int IDX_W      = bftl_pkg::IDX_W;
  localparam int DATA_W     = 2 * bftl_pkg::SAMPLE_W;
  localparam int POS_W      = bftl_pkg::POS_W;

  // Beat decode signals.
  logic                    accept, is_lookup, in_window, credit_ok;
  logic signed [POS_W:0]   r_off_full, z_off_full;
  logic [OFF_W-1:0]        r_off, z_off;
  logic [IDX_W-1:0]        r_idx, z_idx;
  logic [FRAC_W-1:0]       r_fr, z_fr;
  logic                    r_sat, z_sat, r_step, z_step;
  logic [COL_W-1:0]        col_lo, col_hi;
  logic [ROW_W-1:0]        row_lo, row_hi;
  logic [FW1-1:0]          r_w, z_w, r_wi, z_wi;
  logic                    wr_ok;

  // Sequencer state.
  logic                    busy_r, busy_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    seq_last;
  logic                    lookup_r, oob_r, wr_ok_r;
  logic [AW-1:0]           base_lo_r, base_hi_r;
  logic [COL_W-1:0]        col_lo_r, col_hi_r;
  logic [WGT_W-1:0]        w_r [4];
  logic [DATA_W-1:0]       wdata_r;

  // Table memory port.
  logic [DATA_W-1:0]       grid_mem [GRID_DEPTH];
  logic [DATA_W-1:0]       rd_data_r;
  logic [AW-1:0]           mem_addr;
  logic                    mem_we, mem_re;
  bftl_pkg::bftl_tag_t     tag_nxt, tag_r;

  assign is_lookup = (in_data.operation == bftl_pkg::OP_LOOKUP);

  // Window check and split of each offset into grid index and fraction.
  always_comb begin
    in_window = (in_data.radial_position >= bftl_pkg::R_LO_POS) &&
                (in_data.radial_position <= bftl_pkg::R_HI_POS) &&
                (in_data.axial_position >= bftl_pkg::Z_LO_POS) &&
                (in_data.axial_position <= bftl_pkg::Z_HI_POS);
    r_off_full = (POS_W + 1)'(in_data.radial_position) - (POS_W + 1)'(bftl_pkg::R_LO_POS);
    z_off_full = (POS_W + 1)'(in_data.axial_position) - (POS_W + 1)'(bftl_pkg::Z_LO_POS);
    r_off = r_off_full[OFF_W-1:0];
    z_off = z_off_full[OFF_W-1:0];
    r_idx = r_off[OFF_W-1:FRAC_W];
    z_idx = z_off[OFF_W-1:FRAC_W];

    // An index past the last point sticks to it with a zero fraction.
    r_sat = (32'(r_idx) > 32'(RADIAL_POINTS - 1));
    z_sat = (32'(z_idx) > 32'(AXIAL_POINTS - 1));
    r_fr  = r_sat ? '0 : r_off[FRAC_W-1:0];
    z_fr  = z_sat ? '0 : z_off[FRAC_W-1:0];

    // The high neighbour equals the low one for a zero fraction or the last point.
    r_step = (r_fr != '0) && (32'(r_idx) < 32'(RADIAL_POINTS - 1));
    z_step = (z_fr != '0) && (32'(z_idx) < 32'(AXIAL_POINTS - 1));
    col_lo = r_sat ? COL_W'(RADIAL_POINTS - 1) : COL_W'(r_idx);
    col_hi = r_step ? COL_W'(col_lo + 1'b1) : col_lo;
    row_lo = z_sat ? ROW_W'(AXIAL_POINTS - 1) : ROW_W'(z_idx);
    row_hi = z_step ? ROW_W'(row_lo + 1'b1) : row_lo;

    // Load beats reuse the low row and column path.
    if (!is_lookup) begin
      col_lo = COL_W'(in_data.column_index);
      row_lo = ROW_W'(in_data.row_index);
    end

    r_w  = FW1'(r_fr);
    z_w  = FW1'(z_fr);
    r_wi = FW1'(bftl_pkg::STEP) - r_w;
    z_wi = FW1'(bftl_pkg::STEP) - z_w;

    wr_ok = (32'(in_data.row_index) < 32'(AXIAL_POINTS)) &&
            (32'(in_data.column_index) < 32'(RADIAL_POINTS));
  end

  // The sequencer frees up in the cycle of its last memory access.
  assign seq_last = busy_r && (!lookup_r || oob_r || (cnt_r == 2'd3));
  assign in_stall = (busy_r && !seq_last) || !credit_ok;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (seq_last) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Beat payload captured at acceptance: row bases, columns and weights.
  always_ff @(posedge clk) begin
    if (accept) begin
      lookup_r  <= is_lookup;
      oob_r     <= !in_window;
      wr_ok_r   <= wr_ok;
      base_lo_r <= AW'(AW'(row_lo) * AW'(RADIAL_POINTS));
      base_hi_r <= AW'(AW'(row_hi) * AW'(RADIAL_POINTS));
      col_lo_r  <= col_lo;
      col_hi_r  <= col_hi;
      w_r[0]    <= WGT_W'(r_wi) * WGT_W'(z_wi);
      w_r[1]    <= WGT_W'(r_w) * WGT_W'(z_wi);
      w_r[2]    <= WGT_W'(r_wi) * WGT_W'(z_w);
      w_r[3]    <= WGT_W'(r_w) * WGT_W'(z_w);
      wdata_r   <= {in_data.axial_sample, in_data.radial_sample};
    end
  end

  // At most one access per busy cycle: a load's write or an in-window lookup's four reads.
  assign mem_addr = (cnt_r[1] ? base_hi_r : base_lo_r) +
                    AW'(cnt_r[0] ? col_hi_r : col_lo_r);
  assign mem_we   = busy_r && !lookup_r && wr_ok_r;
  assign mem_re   = busy_r && lookup_r && !oob_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= wdata_r;
    end
    if (mem_re) begin
      rd_data_r <= grid_mem[mem_addr];
    end
  end

  // The tag follows the read data into the accumulator.
  always_comb begin
    tag_nxt.valid  = busy_r && lookup_r;
    tag_nxt.first  = (cnt_r == 2'd0);
    tag_nxt.last   = seq_last;
    tag_nxt.oob    = oob_r;
    tag_nxt.weight = w_r[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  bftl_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_data      (rd_data_r),
    .tag_in       (tag_r),
    .lookup_start (accept && is_lookup),
    .credit_ok    (credit_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
